>>> hdl/tgm_pkg.sv
// Package for the tile grid mesh emitter: shared types, codes and face tables.
// Used by tgm_front, tgm_fifo, tgm_back and tile_grid_mesh_emitter.
`timescale 1ns / 1ps

package tgm_pkg;

	localparam int GRID_WIDTH  = 16;
	localparam int GRID_LENGTH = 16;

	localparam int VERTS_PER_FACE = 6;
	localparam int DIV_CYCLES     = 4;  // 8-bit quotient, two bits per cycle
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

	localparam int S_TDATA_W = 56;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 48;

	// configuration register indexes
	localparam logic [1:0] REG_TILE_TEXELS   = 2'd0;
	localparam logic [1:0] REG_ATLAS_SHIFT   = 2'd1;
	localparam logic [1:0] REG_TILES_PER_ROW = 2'd2;

	localparam logic [8:0] RST_TILE_TEXELS   = 9'd16;
	localparam logic [3:0] RST_ATLAS_SHIFT   = 4'd8;
	localparam logic [8:0] RST_TILES_PER_ROW = 9'd16;

	// cell kinds
	localparam logic [1:0] KIND_EMPTY = 2'd0;
	localparam logic [1:0] KIND_SOLID = 2'd1;

	// face codes, equal to the normal code of the face
	localparam logic [2:0] FACE_FLOOR   = 3'd0;
	localparam logic [2:0] FACE_CEILING = 3'd1;
	localparam logic [2:0] FACE_SOUTH   = 3'd2;
	localparam logic [2:0] FACE_NORTH   = 3'd3;
	localparam logic [2:0] FACE_WEST    = 3'd4;
	localparam logic [2:0] FACE_EAST    = 3'd5;

	typedef struct packed {
		logic [8:0] tile_texels;
		logic [3:0] atlas_shift;
		logic [8:0] tiles_per_row;
	} cfg_t;

	typedef struct packed {
		logic [5:0][7:0] tile;  // indexed by face code
		logic [3:0]      col;
		logic [3:0]      row;
		logic [1:0]      kind;
	} cell_t;

	// one face worth of work, front to back
	typedef struct packed {
		logic        last;
		logic [15:0] v1;
		logic [15:0] v0;
		logic [15:0] u1;
		logic [15:0] u0;
		logic [3:0]  col;
		logic [3:0]  row;
		logic [2:0]  face;
	} face_t;

	// unit cube corners: bit0 x, bit1 y, bit2 z
	localparam logic [2:0] CORNER_XYZ [8] = '{
		3'b000, 3'b100, 3'b101, 3'b001, 3'b010, 3'b110, 3'b111, 3'b011
	};

	localparam logic [2:0] FACE_CORNER [6][6] = '{
		'{3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd2},
		'{3'd4, 3'd6, 3'd5, 3'd4, 3'd7, 3'd6},
		'{3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4},
		'{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
		'{3'd3, 3'd0, 3'd4, 3'd3, 3'd4, 3'd7},
		'{3'd1, 3'd2, 3'd6, 3'd1, 3'd6, 3'd5}
	};

	// bit0 picks u1 over u0, bit1 picks v1 over v0
	localparam logic [1:0] FACE_UVSEL [6][6] = '{
		'{2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3},
		'{2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2},
		'{2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2},
		'{2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2},
		'{2'd0, 2'd1, 2'd3, 2'd0, 2'd3, 2'd2}
	};

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
			input logic [8:0] d);
		logic [8:0] t;
		logic [8:0] diff;
		t    = {rem, nb};
		diff = t - d;
		if (t >= d) begin
			div_step = {1'b1, diff[7:0]};
		end else begin
			div_step = {1'b0, t[7:0]};
		end
	endfunction

	// half-texel count to saturated Q0.16
	function automatic logic [15:0] to_q16(input logic [18:0] halves, input logic [3:0] sh);
		logic [33:0] q;
		q = {15'b0, halves} << sh;
		if (q > 34'd65535) begin
			to_q16 = 16'hFFFF;
		end else begin
			to_q16 = q[15:0];
		end
	endfunction

endpackage

>>> hdl/tgm_front.sv
// Front end: takes cells, drops the ones that emit nothing, and per face works out
// atlas column/row (radix-4 divider) and the four UV values. Uses tgm_pkg.
`timescale 1ns / 1ps

module tgm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgm_pkg::cfg_t                 cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tgm_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [tgm_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          push,
	output tgm_pkg::face_t                wdata,
	input  logic                          full
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIV  = 4'b0010,
		F_MUL  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t        state_q;
	logic           hold_v_q;
	tgm_pkg::cell_t hold_q;
	tgm_pkg::cell_t cell_q;
	tgm_pkg::cell_t s_cell;
	logic [2:0]     face_q;
	logic [7:0]     num_q;
	logic [7:0]     rem_q;
	logic [1:0]     cnt_q;
	logic [16:0]    prod_c_q;
	logic [16:0]    prod_r_q;

	logic       last_face;
	logic       take;
	logic       start_ok;
	logic [2:0] first_face;
	logic [2:0] next_face;
	logic [8:0] divisor;
	logic [8:0] step1;
	logic [8:0] step2;
	logic [3:0] sh;
	logic [17:0] sum_c;
	logic [17:0] sum_r;
	logic [18:0] half_u1;
	logic [18:0] half_v0;

	always_comb begin
		s_cell.kind = s_tuser;
		s_cell.row  = s_tdata[3:0];
		s_cell.col  = s_tdata[7:4];
		s_cell.tile[tgm_pkg::FACE_FLOOR]   = s_tdata[15:8];
		s_cell.tile[tgm_pkg::FACE_CEILING] = s_tdata[23:16];
		s_cell.tile[tgm_pkg::FACE_NORTH]   = s_tdata[31:24];
		s_cell.tile[tgm_pkg::FACE_SOUTH]   = s_tdata[39:32];
		s_cell.tile[tgm_pkg::FACE_WEST]    = s_tdata[47:40];
		s_cell.tile[tgm_pkg::FACE_EAST]    = s_tdata[55:48];
	end

	// the holding slot refills in the cycle it hands its cell on
	assign s_tready  = !hold_v_q || take;
	assign last_face = (face_q == tgm_pkg::FACE_CEILING) || (face_q == tgm_pkg::FACE_EAST);
	assign push      = (state_q == F_PUSH) && !full;
	assign take      = hold_v_q && ((state_q == F_IDLE) || (push && last_face));
	assign start_ok  = ((hold_q.kind == tgm_pkg::KIND_EMPTY) ||
	                    (hold_q.kind == tgm_pkg::KIND_SOLID)) &&
	                   ({5'b0, hold_q.row} < 9'(tgm_pkg::GRID_LENGTH)) &&
	                   ({5'b0, hold_q.col} < 9'(tgm_pkg::GRID_WIDTH));
	assign first_face = (hold_q.kind == tgm_pkg::KIND_EMPTY) ? tgm_pkg::FACE_FLOOR
	                                                         : tgm_pkg::FACE_SOUTH;
	assign next_face  = face_q + 3'd1;

	// zero tiles per row behaves as one
	assign divisor = (cfg.tiles_per_row == 9'd0) ? 9'd1 : cfg.tiles_per_row;
	assign step1   = tgm_pkg::div_step(rem_q, num_q[7], divisor);
	assign step2   = tgm_pkg::div_step(step1[7:0], num_q[6], divisor);

	// UVs in half-texel units, then shifted left by 15 - atlas_shift
	assign sh      = 4'd15 - cfg.atlas_shift;
	assign sum_c   = {1'b0, prod_c_q} + {9'b0, cfg.tile_texels};
	assign sum_r   = {1'b0, prod_r_q} + {9'b0, cfg.tile_texels};
	assign half_u1 = (sum_c == 18'd0) ? 19'd0 : ({sum_c, 1'b0} - 19'd1);
	assign half_v0 = (sum_r == 18'd0) ? 19'd0 : ({sum_r, 1'b0} - 19'd1);

	always_comb begin
		wdata.face = face_q;
		wdata.row  = cell_q.row;
		wdata.col  = cell_q.col;
		wdata.u0   = tgm_pkg::to_q16({1'b0, prod_c_q, 1'b1}, sh);
		wdata.u1   = tgm_pkg::to_q16(half_u1, sh);
		wdata.v0   = tgm_pkg::to_q16(half_v0, sh);
		wdata.v1   = tgm_pkg::to_q16({1'b0, prod_r_q, 1'b1}, sh);
		wdata.last = last_face;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			hold_v_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				hold_v_q <= 1'b1;
			end else if (take) begin
				hold_v_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (take && start_ok) begin
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (cnt_q == 2'(tgm_pkg::DIV_CYCLES - 1)) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push) begin
						if (!last_face || (take && start_ok)) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_IDLE;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hold_q <= s_cell;
		end
		if (take && start_ok) begin
			cell_q <= hold_q;
			face_q <= first_face;
			num_q  <= hold_q.tile[first_face];
			rem_q  <= 8'd0;
			cnt_q  <= 2'd0;
		end else if (push && !last_face) begin
			face_q <= next_face;
			num_q  <= cell_q.tile[next_face];
			rem_q  <= 8'd0;
			cnt_q  <= 2'd0;
		end else if (state_q == F_DIV) begin
			// quotient shifts in at the bottom, dividend out at the top
			num_q <= {num_q[5:0], step1[8], step2[8]};
			rem_q <= step2[7:0];
			cnt_q <= cnt_q + 2'd1;
		end
		if (state_q == F_MUL) begin
			prod_c_q <= {9'b0, rem_q} * {8'b0, cfg.tile_texels};
			prod_r_q <= {9'b0, num_q} * {8'b0, cfg.tile_texels};
		end
	end

endmodule

>>> hdl/tgm_fifo.sv
// Short queue of face records between front and back end.
// Uses tgm_pkg for face_t and the depth.
`timescale 1ns / 1ps

module tgm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tgm_pkg::face_t wdata,
	output logic           full,
	input  logic           pop,
	output tgm_pkg::face_t rdata,
	output logic           empty
);

	tgm_pkg::face_t               mem_q [tgm_pkg::FIFO_DEPTH];
	logic [tgm_pkg::FIFO_AW-1:0]  wptr_q;
	logic [tgm_pkg::FIFO_AW-1:0]  rptr_q;
	logic [tgm_pkg::FIFO_AW:0]    count_q;

	assign full  = (count_q == (tgm_pkg::FIFO_AW + 1)'(tgm_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("face queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("face queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (tgm_pkg::FIFO_AW + 1)'(tgm_pkg::FIFO_DEPTH))
		else $error("face queue count out of range");
`endif

endmodule

>>> hdl/tgm_back.sv
// Back end: expands each face record into six vertices through the output register.
// Uses tgm_pkg for face_t and the unit-cube tables.
`timescale 1ns / 1ps

module tgm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tgm_pkg::face_t                rdata,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tgm_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	tgm_pkg::face_t cur_q;
	logic           cur_v_q;
	logic [2:0]     k_q;
	logic           m_tvalid_q;
	logic           m_tlast_q;
	logic [tgm_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic       adv;
	logic       k_end;
	logic [2:0] corner;
	logic [2:0] xyz;
	logic [1:0] uvsel;
	logic [4:0] pos_x;
	logic [4:0] pos_z;
	logic [15:0] tex_u;
	logic [15:0] tex_v;

	assign adv   = !m_tvalid_q || m_tready;
	assign k_end = (k_q == 3'(tgm_pkg::VERTS_PER_FACE - 1));
	assign pop   = !empty && (!cur_v_q || (adv && k_end));

	assign corner = tgm_pkg::FACE_CORNER[cur_q.face][k_q];
	assign uvsel  = tgm_pkg::FACE_UVSEL[cur_q.face][k_q];
	assign xyz    = tgm_pkg::CORNER_XYZ[corner];
	assign pos_x  = {1'b0, cur_q.col} + {4'b0, xyz[0]};
	assign pos_z  = {1'b0, cur_q.row} + {4'b0, xyz[2]};
	assign tex_u  = uvsel[0] ? cur_q.u1 : cur_q.u0;
	assign tex_v  = uvsel[1] ? cur_q.v1 : cur_q.v0;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q    <= 1'b0;
			k_q        <= 3'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (adv) begin
				m_tvalid_q <= cur_v_q;
			end
			if (pop) begin
				cur_v_q <= 1'b1;
				k_q     <= 3'd0;
			end else if (adv && cur_v_q) begin
				if (k_end) begin
					cur_v_q <= 1'b0;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rdata;
		end
		if (adv && cur_v_q) begin
			m_tdata_q <= {2'b0, cur_q.face, tex_v, tex_u, pos_z, xyz[1], pos_x};
			m_tlast_q <= cur_q.last && k_end;
		end
	end

`ifndef SYNTHESIS
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> (k_q <= 3'(tgm_pkg::VERTS_PER_FACE - 1)))
		else $error("vertex counter out of range");
`endif

endmodule

>>> hdl/tile_grid_mesh_emitter.sv
// Top level of the tile grid mesh emitter: configuration registers, front end,
// face queue and back end. Uses tgm_pkg, tgm_front, tgm_fifo, tgm_back.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser: cell_kind; tdata: cell fields
//  m_*      out  m_tvalid/m_tready    tdata: vertex fields; tlast: last_vertex
//  cfg_*    in   cfg_we               cfg_addr register index, cfg_wdata value
//
// One vertex per cycle while m_tready is high: 12 vertices for an empty cell, 24 for a solid one.
// Per face the front runs the radix-4 divider, one multiply and one queue write,
// matched to the six vertices the back emits per face.
// Cells of other kinds are dropped without output.
// Reset clears the control state and loads the register defaults.
// A stalled m_tready backs up through the face queue to s_tready.
`timescale 1ns / 1ps

module tile_grid_mesh_emitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_row, cell_col, tile_floor, tile_ceiling, tile_north, tile_south,
	// tile_west, tile_east
	input  logic [55:0] s_tdata,
	// cell_kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v, normal_dir, two zero bits
	output logic [47:0] m_tdata,
	output logic        m_tlast
);

	tgm_pkg::cfg_t  cfg_q;
	tgm_pkg::face_t wdata;
	tgm_pkg::face_t rdata;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_texels   <= tgm_pkg::RST_TILE_TEXELS;
			cfg_q.atlas_shift   <= tgm_pkg::RST_ATLAS_SHIFT;
			cfg_q.tiles_per_row <= tgm_pkg::RST_TILES_PER_ROW;
		end else if (cfg_we) begin
			case (cfg_addr)
				tgm_pkg::REG_TILE_TEXELS: begin
					cfg_q.tile_texels <= cfg_wdata;
				end
				tgm_pkg::REG_ATLAS_SHIFT: begin
					cfg_q.atlas_shift <= cfg_wdata[3:0];
				end
				tgm_pkg::REG_TILES_PER_ROW: begin
					cfg_q.tiles_per_row <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	tgm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.wdata    (wdata),
		.full     (full)
	);

	tgm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	tgm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rdata    (rdata),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
